>>> hw/rtl/ppdf_pkg.sv
// Types and constants shared by the PNG pixel to display format converter.
package ppdf_pkg;

	typedef enum logic [1:0] {
		OP_PIXEL    = 2'd0,
		OP_PAL_WR   = 2'd1,
		OP_TRANS_WR = 2'd2,
		OP_START    = 2'd3
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  table_index;
		logic [23:0] table_value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic [7:0]  alpha;
		logic        image_has_alpha;
	} out_word_t;

	// Kind bits of the pixel_type register.
	localparam logic [2:0] KIND_PALETTE = 3'h1;
	localparam logic [2:0] KIND_COLOR   = 3'h2;
	localparam logic [2:0] KIND_ALPHA   = 3'h4;

	// Output packing codes.
	localparam logic [1:0] FMT_RGB565   = 2'd0;
	localparam logic [1:0] FMT_ABGR8888 = 2'd1;
	localparam logic [1:0] FMT_RGBA8888 = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PIXEL_TYPE   = 2'd0;
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
	localparam logic [1:0] REG_TRANS_MAP    = 2'd2;

	localparam logic [2:0] PIXEL_TYPE_RESET   = KIND_COLOR;
	localparam logic [1:0] PIXEL_FORMAT_RESET = FMT_RGB565;
	localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

endpackage

>>> hw/rtl/ppdf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ppdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/png_pixel_to_display_format.sv
// Top level of the PNG pixel to display format converter.
//
// Decoded PNG words enter on the in channel (valid/ready). A word is either a
// pixel, a palette write, a transparency write or an image start; only pixels
// produce a word on the out channel, holding the packed display pixel, its
// alpha and the sticky image_has_alpha flag.
// A pixel passes two registers: the read stage, where the synchronous palette
// and transparency reads land with the word, and the output register.
// Throughput is one word per clock while the out channel is not stalled; the
// palette and transparency RAMs take one write or one read per word.
// A stalled receiver holds the output register; one more word may sit in the
// read stage, after which in_ready drops until the output is taken.
// Reset clears the pipeline, loads the register defaults (pixel_type 2,
// pixel_format 0, no transparency map), marks every transparency entry as 255
// and clears the alpha flag. The palette is undefined until written. An image
// start resets the transparency entries through per-entry valid bits, so there
// is no clearing pass, and clears the flag as it leaves the read stage.
module png_pixel_to_display_format #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppdf_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ppdf_pkg::out_word_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	import ppdf_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam int VDEPTH = 1 << AW;

	// Configuration registers.
	logic [2:0] pixel_type_q;
	logic [1:0] pixel_format_q;
	logic       trans_map_q;
	logic       cfg_wr;
	logic [1:0] cfg_idx;

	// Pipeline and state.
	logic              in_fire;
	logic              s1_adv;
	logic              valid_s1;
	in_word_t          item_s1;
	logic              in_range_s1;
	logic              tvld_s1;
	logic              out_valid_q;
	out_word_t         out_data_q;
	logic              alpha_seen_q;
	logic [VDEPTH-1:0] trans_vld_q;

	logic          pix_in_range;
	logic          tidx_in_range;
	logic          pal_we;
	logic          trans_we;
	logic          rd_en;
	logic [23:0]   pal_rdata;
	logic [7:0]    trans_rdata;

	logic          truecolor;
	logic [7:0]    r_c, g_c, b_c, a_c;
	logic [7:0]    trans_alpha;
	logic [31:0]   word_c;
	logic          seen_c;

	// ---------------------------------------------------------------- APB port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_type_q   <= PIXEL_TYPE_RESET;
			pixel_format_q <= PIXEL_FORMAT_RESET;
			trans_map_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PIXEL_TYPE:   pixel_type_q   <= pwdata[2:0];
				REG_PIXEL_FORMAT: pixel_format_q <= pwdata[1:0];
				REG_TRANS_MAP:    trans_map_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PIXEL_TYPE:   prdata = {29'd0, pixel_type_q};
			REG_PIXEL_FORMAT: prdata = {30'd0, pixel_format_q};
			REG_TRANS_MAP:    prdata = {31'd0, trans_map_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------ input stage
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	assign pix_in_range  = {1'b0, in_data.byte0} < 9'(PALETTE_ENTRIES);
	assign tidx_in_range = {1'b0, in_data.table_index} < 9'(PALETTE_ENTRIES);
	assign pal_we   = in_fire && (in_data.operation == OP_PAL_WR) && tidx_in_range;
	assign trans_we = in_fire && (in_data.operation == OP_TRANS_WR) && tidx_in_range;
	assign rd_en    = in_fire && (in_data.operation == OP_PIXEL);

	ppdf_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_ENTRIES)
	) u_pal_ram (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_data.table_index[AW-1:0]),
		.wdata(in_data.table_value),
		.re   (rd_en),
		.raddr(in_data.byte0[AW-1:0]),
		.rdata(pal_rdata)
	);

	ppdf_ram #(
		.WIDTH(8),
		.DEPTH(PALETTE_ENTRIES)
	) u_trans_ram (
		.clk  (clk),
		.we   (trans_we),
		.waddr(in_data.table_index[AW-1:0]),
		.wdata(in_data.table_value[7:0]),
		.re   (rd_en),
		.raddr(in_data.byte0[AW-1:0]),
		.rdata(trans_rdata)
	);

	// An entry without its valid bit has not been written since the last
	// image start and reads as opaque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_vld_q <= '0;
		end else if (in_fire && (in_data.operation == OP_START)) begin
			trans_vld_q <= '0;
		end else if (trans_we) begin
			trans_vld_q[in_data.table_index[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1     <= in_data;
			in_range_s1 <= pix_in_range;
			tvld_s1     <= pix_in_range && trans_vld_q[in_data.byte0[AW-1:0]];
		end
	end

	// ------------------------------------------------------------- read stage
	assign truecolor   = (pixel_type_q == KIND_COLOR) ||
	                     (pixel_type_q == (KIND_COLOR | KIND_ALPHA));
	assign trans_alpha = tvld_s1 ? trans_rdata : ALPHA_OPAQUE;

	always_comb begin
		a_c = ALPHA_OPAQUE;
		if (truecolor) begin
			r_c = item_s1.byte0;
			g_c = item_s1.byte1;
			b_c = item_s1.byte2;
			if (((pixel_type_q & KIND_ALPHA) != 3'd0) || trans_map_q) begin
				a_c = item_s1.byte3;
			end
		end else begin
			r_c = in_range_s1 ? pal_rdata[23:16] : 8'd0;
			g_c = in_range_s1 ? pal_rdata[15:8]  : 8'd0;
			b_c = in_range_s1 ? pal_rdata[7:0]   : 8'd0;
			priority if ((pixel_type_q & (KIND_ALPHA | KIND_COLOR)) == KIND_ALPHA) begin
				a_c = item_s1.byte1;
			end else if (trans_map_q) begin
				a_c = ((pixel_type_q & KIND_COLOR) == 3'd0) ? item_s1.byte1 : trans_alpha;
			end else begin
				a_c = ALPHA_OPAQUE;
			end
		end
	end

	always_comb begin
		unique case (pixel_format_q)
			FMT_ABGR8888: word_c = {a_c, b_c, g_c, r_c};
			FMT_RGBA8888: word_c = {r_c, g_c, b_c, a_c};
			default:      word_c = {16'd0, r_c[7:3], g_c[7:2], b_c[7:3]};
		endcase
	end

	assign seen_c = alpha_seen_q || (a_c != ALPHA_OPAQUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_seen_q <= 1'b0;
		end else if (s1_adv) begin
			if (item_s1.operation == OP_START) begin
				alpha_seen_q <= 1'b0;
			end else if (item_s1.operation == OP_PIXEL) begin
				alpha_seen_q <= seen_c;
			end
		end
	end

	// ----------------------------------------------------------- output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= (item_s1.operation == OP_PIXEL);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (item_s1.operation == OP_PIXEL)) begin
			out_data_q.pixel_word      <= word_c;
			out_data_q.alpha           <= a_c;
			out_data_q.image_has_alpha <= seen_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------- assertions
	a_out_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && (item_s1.operation == OP_PIXEL)))
		else $error("output word without a pixel in the read stage");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled while the pipeline can move");

	a_start_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (item_s1.operation == OP_START)) |=> !alpha_seen_q)
		else $error("image start did not clear the alpha flag");

	a_start_clears_trans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_data.operation == OP_START)) |=> (trans_vld_q == '0))
		else $error("image start did not reset the transparency entries");

endmodule

>>> verif/tb_png_pixel_to_display_format.sv
// Self-checking testbench for the PNG pixel to display format converter.
module tb_png_pixel_to_display_format;
	timeunit 1ns;
	timeprecision 1ps;

	import ppdf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	png_pixel_to_display_format u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the converter state, updated as words are accepted.
	logic [23:0] palette_copy [256];
	logic [7:0] trans_copy [256];
	logic alpha_seen_copy = 1'b0;
	logic [2:0] cfg_type = PIXEL_TYPE_RESET;
	logic [1:0] cfg_format = PIXEL_FORMAT_RESET;
	logic cfg_map = 1'b0;

	in_word_t pending_words [$];
	out_word_t pixels_due [$];
	logic [7:0] palette_filled [$];
	int error_count = 0;
	int send_wait = 0;
	int send_idle_max = 0;
	int recv_wait = 0;
	int recv_idle_max = 0;
	int recv_next = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int idle_draw(int maxv);
		return (maxv == 0) ? 0 : $urandom_range(0, maxv);
	endfunction

	function automatic logic is_truecolor(logic [2:0] t);
		return t == KIND_COLOR || t == (KIND_COLOR | KIND_ALPHA);
	endfunction

	function automatic logic [31:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		case (cfg_format)
			FMT_ABGR8888: return {a, b, g, r};
			FMT_RGBA8888: return {r, g, b, a};
			default: return {16'h0000, r[7:3], g[7:2], b[7:3]};
		endcase
	endfunction

	function automatic void convert_word(in_word_t w);
		out_word_t res;
		logic [23:0] color;
		logic [7:0] a;
		case (w.operation)
			OP_PAL_WR: palette_copy[w.table_index] = w.table_value;
			OP_TRANS_WR: trans_copy[w.table_index] = w.table_value[7:0];
			OP_START: begin
				foreach (trans_copy[i]) trans_copy[i] = ALPHA_OPAQUE;
				alpha_seen_copy = 1'b0;
			end
			OP_PIXEL: begin
				a = ALPHA_OPAQUE;
				if (is_truecolor(cfg_type)) begin
					if ((cfg_type & KIND_ALPHA) != 0 || cfg_map) a = w.byte3;
					res.pixel_word = pack_pixel(w.byte0, w.byte1, w.byte2, a);
				end else begin
					color = palette_copy[w.byte0];
					if ((cfg_type & (KIND_ALPHA | KIND_COLOR)) == KIND_ALPHA)
						a = w.byte1;
					else if (cfg_map)
						a = ((cfg_type & KIND_COLOR) == 0) ? w.byte1 : trans_copy[w.byte0];
					res.pixel_word = pack_pixel(color[23:16], color[15:8], color[7:0], a);
				end
				if (a != ALPHA_OPAQUE) alpha_seen_copy = 1'b1;
				res.alpha = a;
				res.image_has_alpha = alpha_seen_copy;
				pixels_due.push_back(res);
			end
		endcase
	endfunction

	function automatic void check_pixel(out_word_t got);
		out_word_t want;
		if (pixels_due.size() == 0) begin
			$error("pixel word %h arrived with nothing outstanding", got);
			error_count++;
			return;
		end
		want = pixels_due.pop_front();
		if (got.pixel_word !== want.pixel_word) begin
			$error("pixel_word: expected %h, got %h", want.pixel_word, got.pixel_word);
			error_count++;
		end
		if (got.alpha !== want.alpha) begin
			$error("alpha: expected %h, got %h", want.alpha, got.alpha);
			error_count++;
		end
		if (got.image_has_alpha !== want.image_has_alpha) begin
			$error("image_has_alpha: expected %b, got %b", want.image_has_alpha,
				got.image_has_alpha);
			error_count++;
		end
	endfunction

	// Sender: the wait drawn with a word delays the word after it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) convert_word(in_data);
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending_words.size() != 0) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
					send_wait <= idle_draw(send_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: after each word taken, hold off for a freshly drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				check_pixel(out_data);
				recv_next = idle_draw(recv_idle_max);
			end else begin
				recv_next = recv_wait;
			end
			if (recv_next != 0) begin
				out_ready <= 1'b0;
				recv_wait <= recv_next - 1;
			end else begin
				out_ready <= 1'b1;
				recv_wait <= 0;
			end
		end
	end

	function automatic logic [7:0] alpha_byte();
		return $urandom_range(0, 1) ? ALPHA_OPAQUE : 8'($urandom_range(0, 255));
	endfunction

	task automatic push_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
		in_word_t w;
		w.operation = OP_PIXEL;
		w.byte0 = b0;
		w.byte1 = b1;
		w.byte2 = b2;
		w.byte3 = b3;
		w.table_index = 8'($urandom_range(0, 255));
		w.table_value = 24'($urandom_range(0, 24'hFFFFFF));
		pending_words.push_back(w);
	endtask

	task automatic push_table(op_t op, logic [7:0] idx, logic [23:0] val);
		in_word_t w;
		w.operation = op;
		w.byte0 = 8'($urandom_range(0, 255));
		w.byte1 = 8'($urandom_range(0, 255));
		w.byte2 = 8'($urandom_range(0, 255));
		w.byte3 = 8'($urandom_range(0, 255));
		w.table_index = idx;
		w.table_value = val;
		if (op == OP_PAL_WR) palette_filled.push_back(idx);
		pending_words.push_back(w);
	endtask

	// Palette-reading pixels only use entries already written.
	task automatic push_random();
		int pick;
		logic [7:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			if (is_truecolor(cfg_type))
				idx = 8'($urandom_range(0, 255));
			else
				idx = palette_filled[$urandom_range(0, palette_filled.size() - 1)];
			push_pixel(idx, alpha_byte(), 8'($urandom_range(0, 255)), alpha_byte());
		end else if (pick < 75) begin
			push_table(OP_PAL_WR, 8'($urandom_range(0, 255)),
				24'($urandom_range(0, 24'hFFFFFF)));
		end else if (pick < 88) begin
			if ($urandom_range(0, 1))
				idx = palette_filled[$urandom_range(0, palette_filled.size() - 1)];
			else
				idx = 8'($urandom_range(0, 255));
			push_table(OP_TRANS_WR, idx, {16'($urandom_range(0, 16'hFFFF)), alpha_byte()});
		end else begin
			push_table(OP_START, 8'($urandom_range(0, 255)),
				24'($urandom_range(0, 24'hFFFFFF)));
		end
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PIXEL_TYPE: cfg_type = val[2:0];
			REG_PIXEL_FORMAT: cfg_format = val[1:0];
			REG_TRANS_MAP: cfg_map = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [2:0] t, logic [1:0] f, logic m);
		reg_write(REG_PIXEL_TYPE, {29'd0, t});
		reg_write(REG_PIXEL_FORMAT, {30'd0, f});
		reg_write(REG_TRANS_MAP, {31'd0, m});
		send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
		recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
	endtask

	// Wait until the sender has no words left and every outstanding pixel is back,
	// then let the pipeline empty of table writes before touching the registers.
	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || in_valid || pixels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [5:0] p;
		foreach (trans_copy[i]) trans_copy[i] = ALPHA_OPAQUE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults after reset: plain truecolor, RGB565, no map.
		send_idle_max = 14;
		recv_idle_max = 14;
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h80, 8'h40, 8'h08, 8'h00);
		push_table(OP_PAL_WR, 8'h00, 24'hFFFFFF);
		push_table(OP_PAL_WR, 8'hFF, 24'h000000);
		push_table(OP_PAL_WR, 8'h5A, 24'hA5C3E1);
		push_table(OP_PAL_WR, 8'hA5, 24'h5A3C1E);
		push_table(OP_TRANS_WR, 8'hFF, 24'hFFFF00);
		push_table(OP_TRANS_WR, 8'h5A, 24'h000080);
		// Transparency writes leave the map flag off, so alpha stays opaque.
		push_pixel(8'h12, 8'h34, 8'h56, 8'h00);
		drain();

		// Palette with color bit and a map: alpha from the transparency store.
		set_config(KIND_PALETTE | KIND_COLOR, FMT_ABGR8888, 1'b1);
		push_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
		push_pixel(8'h5A, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		push_table(OP_START, 8'h00, 24'h000000);
		push_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
		drain();

		// Alpha bit alone: alpha from the second byte.
		set_config(KIND_ALPHA, FMT_RGBA8888, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
		drain();

		// Truecolor with alpha in the unused packing code.
		set_config(KIND_COLOR | KIND_ALPHA, 2'd3, 1'b0);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		push_table(OP_START, 8'hFF, 24'hFFFFFF);
		drain();

		set_config(3'd0, FMT_ABGR8888, 1'b1);
		push_pixel(8'h5A, 8'h7F, 8'h00, 8'h00);
		drain();

		set_config(KIND_COLOR, FMT_RGBA8888, 1'b1);
		push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
		drain();

		set_config(3'd7, FMT_RGB565, 1'b0);
		push_pixel(8'hA5, 8'h00, 8'h00, 8'h00);
		drain();

		// Every combination of kind, packing and map, with random traffic.
		for (int n = 0; n < 64; n++) begin
			p = 6'(n);
			set_config(p[2:0], p[5:4], p[3]);
			repeat ($urandom_range(10, 18)) push_random();
			drain();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
